// File: design/acp_pkg.sv
// Shared types and constants for the box push-out pipeline.
package acp_pkg;

	localparam int POS_W  = 32;
	localparam int SIZE_W = 31;
	localparam int AD_W   = 33;
	localparam int OV_W   = 35;
	localparam int SQ_W   = 66;
	localparam int SUM_W  = 68;
	localparam int LEN_W  = 34;
	localparam int REM_W  = 35;
	localparam int OVL_W  = 33;
	localparam int NUM_W  = 66;
	localparam int DIVN_W = 67;
	localparam int Q_W    = 32;

	localparam logic [1:0] AX_NONE = 2'd0;
	localparam logic [1:0] AX_X    = 2'd1;
	localparam logic [1:0] AX_Y    = 2'd2;
	localparam logic [1:0] AX_Z    = 2'd3;

	typedef struct packed {
		logic [2:0][POS_W-1:0] pos;
		logic [1:0]            axis;
		logic                  neg;
		logic [OVL_W-1:0]      ovl;
		logic [NUM_W-1:0]      num;
	} side_t;

endpackage

// File: design/acp_front.sv
// Front stages: differences, overlaps, squares, axis choice and push numerator.
module acp_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  vld_in,
	input  logic [2:0][acp_pkg::POS_W-1:0]        self_pos,
	input  logic [2:0][acp_pkg::SIZE_W-1:0]       self_size,
	input  logic [2:0][acp_pkg::POS_W-1:0]        other_pos,
	input  logic [2:0][acp_pkg::SIZE_W-1:0]       other_size,
	output logic                                  vld_out,
	output logic [acp_pkg::SUM_W-1:0]             sum,
	output acp_pkg::side_t                        side
);

	logic                               vld_s1, vld_s2, vld_s3;
	logic [2:0][acp_pkg::POS_W-1:0]     pos_s1, pos_s2;
	logic [2:0]                         neg_s1;
	logic [2:0][acp_pkg::AD_W-1:0]      ad_s1;
	logic [2:0][acp_pkg::OV_W-1:0]      ov_s1;
	logic [2:0][acp_pkg::SQ_W-1:0]      sq_s2;
	logic [1:0]                         axis_s2;
	logic                               neg_s2;
	logic [acp_pkg::AD_W-1:0]           ad_sel_s2;
	logic [acp_pkg::OVL_W-1:0]          ovl_s2;
	logic [acp_pkg::SUM_W-1:0]          sum_s3;
	acp_pkg::side_t                     side_s3;

	logic [2:0][acp_pkg::AD_W-1:0]      d_c, ad_c;
	logic [2:0][acp_pkg::OV_W-1:0]      ov_c;
	logic signed [acp_pkg::OV_W-1:0]    o0, o1, o2;
	logic [1:0]                         axis_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_c[k]  = {self_pos[k][acp_pkg::POS_W-1], self_pos[k]} -
				{other_pos[k][acp_pkg::POS_W-1], other_pos[k]};
			ad_c[k] = d_c[k][acp_pkg::AD_W-1] ? (~d_c[k] + 1'b1) : d_c[k];
			ov_c[k] = acp_pkg::OV_W'(self_size[k]) + acp_pkg::OV_W'(other_size[k]) -
				{1'b0, ad_c[k], 1'b0};
		end
	end

	assign o0 = $signed(ov_s1[0]);
	assign o1 = $signed(ov_s1[1]);
	assign o2 = $signed(ov_s1[2]);

	always_comb begin
		if (o0 > 0 && o0 < o1 && o0 < o2) axis_c = acp_pkg::AX_X;
		else if (o1 > 0 && o1 < o2)       axis_c = acp_pkg::AX_Y;
		else if (o2 > 0)                  axis_c = acp_pkg::AX_Z;
		else                              axis_c = acp_pkg::AX_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= self_pos;
			ad_s1  <= ad_c;
			ov_s1  <= ov_c;
			for (int k = 0; k < 3; k++) neg_s1[k] <= d_c[k][acp_pkg::AD_W-1];

			pos_s2 <= pos_s1;
			for (int k = 0; k < 3; k++) sq_s2[k] <= acp_pkg::SQ_W'(ad_s1[k] * ad_s1[k]);
			axis_s2 <= axis_c;
			unique case (axis_c)
				acp_pkg::AX_X: begin
					ad_sel_s2 <= ad_s1[0];
					ovl_s2    <= ov_s1[0][acp_pkg::OVL_W-1:0];
					neg_s2    <= neg_s1[0];
				end
				acp_pkg::AX_Y: begin
					ad_sel_s2 <= ad_s1[1];
					ovl_s2    <= ov_s1[1][acp_pkg::OVL_W-1:0];
					neg_s2    <= neg_s1[1];
				end
				acp_pkg::AX_Z: begin
					ad_sel_s2 <= ad_s1[2];
					ovl_s2    <= ov_s1[2][acp_pkg::OVL_W-1:0];
					neg_s2    <= neg_s1[2];
				end
				default: begin
					ad_sel_s2 <= '0;
					ovl_s2    <= '0;
					neg_s2    <= 1'b0;
				end
			endcase

			sum_s3       <= acp_pkg::SUM_W'(sq_s2[0]) + acp_pkg::SUM_W'(sq_s2[1]) +
				acp_pkg::SUM_W'(sq_s2[2]);
			side_s3.pos  <= pos_s2;
			side_s3.axis <= axis_s2;
			side_s3.neg  <= neg_s2;
			side_s3.ovl  <= ovl_s2;
			side_s3.num  <= acp_pkg::NUM_W'(ad_sel_s2 * ovl_s2);
		end
	end

	assign vld_out = vld_s3;
	assign sum     = sum_s3;
	assign side    = side_s3;

endmodule

// File: design/acp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module acp_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic [acp_pkg::SUM_W-1:0]     val_in,
	input  acp_pkg::side_t                side_in,
	output logic                          vld_out,
	output logic [acp_pkg::LEN_W-1:0]     root,
	output acp_pkg::side_t                side_out
);

	localparam int N = acp_pkg::LEN_W;

	logic                          vld_s  [N+1];
	logic [acp_pkg::SUM_W-1:0]     val_s  [N+1];
	logic [acp_pkg::LEN_W-1:0]     root_s [N+1];
	logic [acp_pkg::REM_W-1:0]     rem_s  [N+1];
	acp_pkg::side_t                side_s [N+1];

	assign vld_s[0]  = vld_in;
	assign val_s[0]  = val_in;
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int I = N - 1 - k;
		logic [acp_pkg::REM_W+1:0] remw, trial;

		assign remw  = {rem_s[k], val_s[k][2*I+1 -: 2]};
		assign trial = (acp_pkg::REM_W+2)'({root_s[k], 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else if (en) vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				val_s[k+1]  <= val_s[k];
				side_s[k+1] <= side_s[k];
				if (remw >= trial) begin
					rem_s[k+1]  <= acp_pkg::REM_W'(remw - trial);
					root_s[k+1] <= {root_s[k][N-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= acp_pkg::REM_W'(remw);
					root_s[k+1] <= {root_s[k][N-2:0], 1'b0};
				end
			end
		end
	end

	assign vld_out  = vld_s[N];
	assign root     = root_s[N];
	assign side_out = side_s[N];

endmodule

// File: design/acp_div.sv
// Pipelined rounded division (num + len) / (2 * len), one quotient bit per stage.
module acp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic [acp_pkg::LEN_W-1:0]     len_in,
	input  acp_pkg::side_t                side_in,
	output logic                          vld_out,
	output logic [acp_pkg::Q_W-1:0]       quo,
	output logic [acp_pkg::LEN_W-1:0]     len_out,
	output acp_pkg::side_t                side_out
);

	localparam int N = acp_pkg::Q_W;

	logic                          vld_s  [N+1];
	logic [acp_pkg::DIVN_W-1:0]    rem_s  [N+1];
	logic [acp_pkg::LEN_W-1:0]     len_s  [N+1];
	logic [acp_pkg::Q_W-1:0]       q_s    [N+1];
	acp_pkg::side_t                side_s [N+1];

	// first stage: add half the divisor for rounding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else if (en) vld_s[0] <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= acp_pkg::DIVN_W'(side_in.num) + acp_pkg::DIVN_W'(len_in);
			len_s[0]  <= len_in;
			q_s[0]    <= '0;
			side_s[0] <= side_in;
		end
	end

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam int B = N - 1 - j;
		logic [acp_pkg::DIVN_W-1:0] shd;

		assign shd = acp_pkg::DIVN_W'({len_s[j], 1'b0}) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[j+1] <= 1'b0;
			else if (en) vld_s[j+1] <= vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[j+1]  <= len_s[j];
				side_s[j+1] <= side_s[j];
				if (rem_s[j] >= shd) begin
					rem_s[j+1] <= rem_s[j] - shd;
					q_s[j+1]   <= q_s[j] | (acp_pkg::Q_W'(1) << B);
				end else begin
					rem_s[j+1] <= rem_s[j];
					q_s[j+1]   <= q_s[j];
				end
			end
		end
	end

	assign vld_out  = vld_s[N];
	assign quo      = q_s[N];
	assign len_out  = len_s[N];
	assign side_out = side_s[N];

endmodule

// File: design/aabb_collision_push_out_core.sv
// Box push-out core: front stages, root, divider, final move and output skid.
// Items pass the front stages, the root, the divider and the output register, in that order.
// Throughput: one item per cycle while input ready is high; the root and divider each resolve one bit per stage.
// A stalled output parks one item in a skid register; input ready drops only while it is full.
// Reset (arst_n low, asynchronous) clears all valid bits; the data registers are not reset.
module aabb_collision_push_out_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// self_pos_x, self_pos_y, self_pos_z, self_size_x, self_size_y, self_size_z,
	// other_pos_x, other_pos_y, other_pos_z, other_size_x, other_size_y, other_size_z, pad
	input  logic [383:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// new_pos_x, new_pos_y, new_pos_z, moved_axis, pad
	output logic [103:0] m_axis_tdata
);

	localparam int EPS_CALC = ((1 << FRAC_BITS) + 500) / 1000;
	localparam int EPS      = (EPS_CALC > 0) ? EPS_CALC : 1;

	logic [2:0][acp_pkg::POS_W-1:0]  self_pos, other_pos;
	logic [2:0][acp_pkg::SIZE_W-1:0] self_size, other_size;

	assign self_pos[0]   = s_axis_tdata[31:0];
	assign self_pos[1]   = s_axis_tdata[63:32];
	assign self_pos[2]   = s_axis_tdata[95:64];
	assign self_size[0]  = s_axis_tdata[126:96];
	assign self_size[1]  = s_axis_tdata[157:127];
	assign self_size[2]  = s_axis_tdata[188:158];
	assign other_pos[0]  = s_axis_tdata[220:189];
	assign other_pos[1]  = s_axis_tdata[252:221];
	assign other_pos[2]  = s_axis_tdata[284:253];
	assign other_size[0] = s_axis_tdata[315:285];
	assign other_size[1] = s_axis_tdata[346:316];
	assign other_size[2] = s_axis_tdata[377:347];

	logic                           en;
	logic                           f_vld, r_vld, d_vld;
	logic [acp_pkg::SUM_W-1:0]      f_sum;
	acp_pkg::side_t                 f_side, r_side, d_side;
	logic [acp_pkg::LEN_W-1:0]      r_len, d_len;
	logic [acp_pkg::Q_W-1:0]        d_quo;

	logic                           skid_vld_q, out_vld_q;
	logic [97:0]                    skid_q, out_q;

	assign en            = ~skid_vld_q;
	assign s_axis_tready = en;

	acp_front u_front (
		.clk, .arst_n, .en,
		.vld_in     (s_axis_tvalid & en),
		.self_pos, .self_size, .other_pos, .other_size,
		.vld_out    (f_vld),
		.sum        (f_sum),
		.side       (f_side)
	);

	acp_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.vld_in   (f_vld),
		.val_in   (f_sum),
		.side_in  (f_side),
		.vld_out  (r_vld),
		.root     (r_len),
		.side_out (r_side)
	);

	acp_div u_div (
		.clk, .arst_n, .en,
		.vld_in   (r_vld),
		.len_in   (r_len),
		.side_in  (r_side),
		.vld_out  (d_vld),
		.quo      (d_quo),
		.len_out  (d_len),
		.side_out (d_side)
	);

	// final move: pick magnitude, apply along the chosen axis, saturate
	logic                           near_zero;
	logic [acp_pkg::Q_W-1:0]        mag;
	logic                           neg_eff;
	logic [acp_pkg::POS_W-1:0]      psel;
	logic signed [acp_pkg::POS_W+1:0] res;
	logic [acp_pkg::POS_W-1:0]      res_sat;
	logic [2:0][acp_pkg::POS_W-1:0] new_pos;
	logic [97:0]                    new_item;

	assign near_zero = d_len < acp_pkg::LEN_W'(EPS);
	assign neg_eff   = ~near_zero & d_side.neg;

	always_comb begin
		if (d_side.axis == acp_pkg::AX_NONE) mag = '0;
		else if (near_zero)
			mag = (d_side.axis == acp_pkg::AX_X) ?
				acp_pkg::Q_W'(((acp_pkg::OVL_W+1)'(d_side.ovl) + 1'b1) >> 1) : '0;
		else mag = d_quo;
	end

	always_comb begin
		unique case (d_side.axis)
			acp_pkg::AX_Y: psel = d_side.pos[1];
			acp_pkg::AX_Z: psel = d_side.pos[2];
			default:       psel = d_side.pos[0];
		endcase
		res = neg_eff ?
			($signed({{2{psel[acp_pkg::POS_W-1]}}, psel}) - $signed({2'b00, mag})) :
			($signed({{2{psel[acp_pkg::POS_W-1]}}, psel}) + $signed({2'b00, mag}));
		if (res > $signed((acp_pkg::POS_W+2)'(32'h7FFF_FFFF)))
			res_sat = 32'h7FFF_FFFF;
		else if (res < -$signed((acp_pkg::POS_W+2)'(34'h0_8000_0000)))
			res_sat = 32'h8000_0000;
		else
			res_sat = res[acp_pkg::POS_W-1:0];
		new_pos = d_side.pos;
		unique case (d_side.axis)
			acp_pkg::AX_X: new_pos[0] = res_sat;
			acp_pkg::AX_Y: new_pos[1] = res_sat;
			acp_pkg::AX_Z: new_pos[2] = res_sat;
			default: ;
		endcase
		new_item = {d_side.axis, new_pos[2], new_pos[1], new_pos[0]};
	end

	logic push, pop;
	assign push = d_vld & en;
	assign pop  = out_vld_q & m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_vld_q) begin
					out_q      <= skid_q;
					skid_vld_q <= 1'b0;
				end else if (push) begin
					out_q <= new_item;
				end else begin
					out_vld_q <= 1'b0;
				end
			end else if (!out_vld_q) begin
				if (push) begin
					out_q     <= new_item;
					out_vld_q <= 1'b1;
				end
			end else if (push) begin
				// output stalled: park the item
				skid_q     <= new_item;
				skid_vld_q <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {6'b0, out_q};

endmodule

// File: design/acp_chk.sv
// Port checker for the box push-out core, bound to the top level.
module acp_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [383:0] s_axis_tdata,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// input backpressure only with a result waiting
	a_bp_out: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("ready low with no result pending");

	// ready drops only after a refused result
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
		else $error("ready fell without output stall");

	// padding stays zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[103:98] == 6'd0)
		else $error("output padding not zero");

endmodule

bind aabb_collision_push_out_core acp_chk u_acp_chk (.*);
